>>> sv/phic_pkg.sv
`timescale 1ns / 1ps

package phic_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int GRP_W        = 18;
    localparam int PSUM_W       = 21;
    localparam int SUM_W        = 32;
    localparam int POS_W        = 16;
    localparam int OFF_W        = 5;

    localparam logic IPV4 = 1'b0;
    localparam logic IPV6 = 1'b1;

    localparam logic [7:0] PROTO_HOPOPT = 8'd0;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_IGMP   = 8'd2;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // byte offset of the stored checksum word within the payload
    localparam logic [OFF_W-1:0] OFF_HOPOPT = 5'd10;
    localparam logic [OFF_W-1:0] OFF_ICMP   = 5'd2;
    localparam logic [OFF_W-1:0] OFF_TCP    = 5'd16;
    localparam logic [OFF_W-1:0] OFF_UDP    = 5'd6;

    localparam logic [15:0] CSUM_ERR      = 16'hFFFF;
    localparam logic        STATUS_OK     = 1'b0;
    localparam logic        STATUS_UNSUPP = 1'b1;

    typedef struct packed {
        logic             ok;
        logic             has_off;
        logic [OFF_W-1:0] off;
    } t_skip_loc;

    typedef struct packed {
        logic              ip_version;
        logic [7:0]        protocol;
        logic [PSUM_W-1:0] pseudo;
        logic [7:0]        payload_byte;
        logic              last_byte;
    } t_acc_in;

    typedef struct packed {
        logic             ok;
        logic             zero_res;
        logic [SUM_W-1:0] sum;
        logic [15:0]      skip;
    } t_fin;

    function automatic t_skip_loc skip_loc(input logic ver, input logic [7:0] proto);
        t_skip_loc loc;
        loc = '0;
        if (ver == IPV4) begin
            unique case (proto)
                PROTO_HOPOPT: loc = '{1'b1, 1'b1, OFF_HOPOPT};
                PROTO_ICMP:   loc = '{1'b1, 1'b1, OFF_ICMP};
                PROTO_IGMP:   loc = '{1'b1, 1'b1, OFF_ICMP};
                PROTO_TCP:    loc = '{1'b1, 1'b1, OFF_TCP};
                PROTO_UDP:    loc = '{1'b1, 1'b1, OFF_UDP};
                default:      loc = '0;
            endcase
        end else begin
            unique case (proto)
                PROTO_HOPOPT: loc = '{1'b1, 1'b0, OFF_W'(0)};
                PROTO_ICMP:   loc = '{1'b1, 1'b1, OFF_ICMP};
                PROTO_ICMPV6: loc = '{1'b1, 1'b1, OFF_ICMP};
                PROTO_TCP:    loc = '{1'b1, 1'b1, OFF_TCP};
                PROTO_UDP:    loc = '{1'b1, 1'b1, OFF_UDP};
                default:      loc = '0;
            endcase
        end
        return loc;
    endfunction

    function automatic logic [GRP_W-1:0] half_sum4(input logic [63:0] v);
        return GRP_W'(v[15:0]) + GRP_W'(v[31:16]) + GRP_W'(v[47:32]) + GRP_W'(v[63:48]);
    endfunction

    function automatic logic [GRP_W-1:0] half_sum2(input logic [63:0] v);
        return GRP_W'(v[15:0]) + GRP_W'(v[31:16]);
    endfunction

endpackage

>>> sv/phic_if.sv
`timescale 1ns / 1ps

interface phic_in_if;
    logic        valid;
    logic        ready;
    logic        ip_version;
    logic [7:0]  protocol;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
    logic        last_byte;

    modport source (
        output valid, ip_version, protocol, src_addr_hi, src_addr_lo,
               dst_addr_hi, dst_addr_lo, payload_len, payload_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, ip_version, protocol, src_addr_hi, src_addr_lo,
               dst_addr_hi, dst_addr_lo, payload_len, payload_byte, last_byte,
        output ready
    );
endinterface

interface phic_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic        status;

    modport source (output valid, checksum, status, input ready);
    modport sink (input valid, checksum, status, output ready);
endinterface

>>> sv/phic_hdr_sum.sv
`timescale 1ns / 1ps

module phic_hdr_sum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    phic_in_if.sink           i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output phic_pkg::t_acc_in o_acc
);

    typedef struct packed {
        logic                                ip_version;
        logic [7:0]                          protocol;
        logic [63:0]                         src_hi;
        logic [63:0]                         src_lo;
        logic [63:0]                         dst_hi;
        logic [63:0]                         dst_lo;
        logic [phic_pkg::LENGTH_WIDTH-1:0]   len;
        logic [7:0]                          payload_byte;
        logic                                last_byte;
    } t_in_item;

    typedef struct packed {
        logic                              ip_version;
        logic [7:0]                        protocol;
        logic                              no_pseudo;
        logic [phic_pkg::GRP_W-1:0]        g_src_hi;
        logic [phic_pkg::GRP_W-1:0]        g_src_lo;
        logic [phic_pkg::GRP_W-1:0]        g_dst_hi;
        logic [phic_pkg::GRP_W-1:0]        g_dst_lo;
        logic [phic_pkg::LENGTH_WIDTH-1:0] len;
        logic [7:0]                        payload_byte;
        logic                              last_byte;
    } t_grp;

    logic              r_v0, r_v1, r_v2;
    logic              w_rdy0, w_rdy1, w_rdy2;
    t_in_item          r_in, n_in;
    t_grp              r_grp, n_grp;
    phic_pkg::t_acc_in r_acc, n_acc;

    assign w_rdy2     = !r_v2 || i_ready;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign w_rdy0     = !r_v0 || w_rdy1;
    assign i_in.ready = w_rdy0;
    assign o_valid    = r_v2;
    assign o_acc      = r_acc;

    always_comb begin
        n_in.ip_version   = i_in.ip_version;
        n_in.protocol     = i_in.protocol;
        n_in.src_hi       = i_in.src_addr_hi;
        n_in.src_lo       = i_in.src_addr_lo;
        n_in.dst_hi       = i_in.dst_addr_hi;
        n_in.dst_lo       = i_in.dst_addr_lo;
        n_in.len          = i_in.payload_len[phic_pkg::LENGTH_WIDTH-1:0];
        n_in.payload_byte = i_in.payload_byte;
        n_in.last_byte    = i_in.last_byte;
    end

    // per-address sums of 16-bit halves
    always_comb begin
        n_grp.ip_version   = r_in.ip_version;
        n_grp.protocol     = r_in.protocol;
        n_grp.len          = r_in.len;
        n_grp.payload_byte = r_in.payload_byte;
        n_grp.last_byte    = r_in.last_byte;
        n_grp.no_pseudo    = (r_in.ip_version == phic_pkg::IPV4) &&
                             ((r_in.protocol == phic_pkg::PROTO_HOPOPT) ||
                              (r_in.protocol == phic_pkg::PROTO_IGMP));
        if (r_in.ip_version == phic_pkg::IPV6) begin
            n_grp.g_src_hi = phic_pkg::half_sum4(r_in.src_hi);
            n_grp.g_src_lo = phic_pkg::half_sum4(r_in.src_lo);
            n_grp.g_dst_hi = phic_pkg::half_sum4(r_in.dst_hi);
            n_grp.g_dst_lo = phic_pkg::half_sum4(r_in.dst_lo);
        end else begin
            n_grp.g_src_hi = '0;
            n_grp.g_src_lo = phic_pkg::half_sum2(r_in.src_lo);
            n_grp.g_dst_hi = '0;
            n_grp.g_dst_lo = phic_pkg::half_sum2(r_in.dst_lo);
        end
    end

    always_comb begin
        n_acc.ip_version   = r_grp.ip_version;
        n_acc.protocol     = r_grp.protocol;
        n_acc.payload_byte = r_grp.payload_byte;
        n_acc.last_byte    = r_grp.last_byte;
        if (r_grp.no_pseudo) begin
            n_acc.pseudo = '0;
        end else begin
            n_acc.pseudo = phic_pkg::PSUM_W'(r_grp.g_src_hi) + phic_pkg::PSUM_W'(r_grp.g_src_lo)
                         + phic_pkg::PSUM_W'(r_grp.g_dst_hi) + phic_pkg::PSUM_W'(r_grp.g_dst_lo)
                         + phic_pkg::PSUM_W'(r_grp.protocol) + phic_pkg::PSUM_W'(r_grp.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_in.valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_in.valid) begin
            r_in <= n_in;
        end
        if (w_rdy1 && r_v0) begin
            r_grp <= n_grp;
        end
        if (w_rdy2 && r_v1) begin
            r_acc <= n_acc;
        end
    end

endmodule

>>> sv/phic_accum.sv
`timescale 1ns / 1ps

module phic_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  phic_pkg::t_acc_in i_acc,
    output logic              o_valid,
    input  logic              i_ready,
    output phic_pkg::t_fin    o_fin
);

    logic [phic_pkg::POS_W-1:0] r_pos, n_pos;
    logic [phic_pkg::SUM_W-1:0] r_sum, n_sum, w_sum_base;
    logic [15:0]                r_skip, n_skip, w_skip_base;
    logic [7:0]                 r_held, n_held;
    logic                       r_ver, w_ver;
    logic [7:0]                 r_proto, w_proto;
    logic [15:0]                w_add;
    logic                       w_first, w_take, w_rdy3;
    phic_pkg::t_skip_loc        w_loc;
    logic                       r_v3;
    phic_pkg::t_fin             r_fin, n_fin;

    assign w_rdy3  = !r_v3 || i_ready;
    assign o_ready = !i_acc.last_byte || w_rdy3;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_v3;
    assign o_fin   = r_fin;

    always_comb begin
        w_first     = (r_pos == '0);
        w_ver       = w_first ? i_acc.ip_version : r_ver;
        w_proto     = w_first ? i_acc.protocol : r_proto;
        w_skip_base = w_first ? 16'h0000 : r_skip;
        w_sum_base  = w_first ? phic_pkg::SUM_W'(i_acc.pseudo) : r_sum;
        w_loc       = phic_pkg::skip_loc(w_ver, w_proto);

        // capture the stored checksum word as it streams past
        n_skip = w_skip_base;
        if (w_loc.has_off && (r_pos == phic_pkg::POS_W'(w_loc.off))) begin
            n_skip = {i_acc.payload_byte, w_skip_base[7:0]};
        end else if (w_loc.has_off &&
                     (r_pos == (phic_pkg::POS_W'(w_loc.off) + phic_pkg::POS_W'(1)))) begin
            n_skip = {w_skip_base[15:8], i_acc.payload_byte};
        end

        if (!r_pos[0]) begin
            n_held = i_acc.payload_byte;
            w_add  = i_acc.last_byte ? {i_acc.payload_byte, 8'h00} : 16'h0000;
        end else begin
            n_held = r_held;
            w_add  = {r_held, i_acc.payload_byte};
        end
        n_sum = w_sum_base + phic_pkg::SUM_W'(w_add);
        n_pos = i_acc.last_byte ? '0 : r_pos + phic_pkg::POS_W'(1);

        n_fin.ok       = w_loc.ok;
        n_fin.zero_res = (w_ver == phic_pkg::IPV6) && (w_proto == phic_pkg::PROTO_HOPOPT);
        n_fin.sum      = n_sum;
        n_fin.skip     = n_skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_skip  <= '0;
            r_held  <= '0;
            r_ver   <= 1'b0;
            r_proto <= '0;
            r_v3    <= 1'b0;
        end else begin
            if (w_take) begin
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_skip  <= n_skip;
                r_held  <= n_held;
                r_ver   <= w_ver;
                r_proto <= w_proto;
            end
            if (w_rdy3) begin
                r_v3 <= w_take && i_acc.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_acc.last_byte) begin
            r_fin <= n_fin;
        end
    end

endmodule

>>> sv/phic_fold.sv
`timescale 1ns / 1ps

module phic_fold (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  phic_pkg::t_fin i_fin,
    phic_out_if.source     o_out
);

    logic                       r_v;
    logic [15:0]                r_csum, n_csum;
    logic                       r_status, n_status;
    logic [phic_pkg::SUM_W-1:0] w_diff;
    logic [16:0]                w_f1;
    logic [15:0]                w_f2;
    logic                       w_rdy;

    assign w_rdy          = !r_v || o_out.ready;
    assign o_ready        = w_rdy;
    assign o_out.valid    = r_v;
    assign o_out.checksum = r_csum;
    assign o_out.status   = r_status;

    always_comb begin
        w_diff = i_fin.sum - phic_pkg::SUM_W'(i_fin.skip);
        w_f1   = 17'(w_diff[31:16]) + 17'(w_diff[15:0]);
        w_f2   = w_f1[15:0] + 16'(w_f1[16]);
        priority if (!i_fin.ok) begin
            n_csum   = phic_pkg::CSUM_ERR;
            n_status = phic_pkg::STATUS_UNSUPP;
        end else if (i_fin.zero_res) begin
            n_csum   = 16'h0000;
            n_status = phic_pkg::STATUS_OK;
        end else begin
            n_csum   = ~w_f2;
            n_status = phic_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_csum   <= n_csum;
            r_status <= n_status;
        end
    end

endmodule

>>> sv/pseudo_header_internet_checksum.sv
`timescale 1ns / 1ps
// Streaming transport checksum with pseudo-header.
// i_in (sink): one payload byte per request, with IP version, protocol,
//   addresses and payload length; these are sampled on the first byte of
//   a packet. last_byte marks the final byte of the packet.
// o_out (source): one request per packet, carrying the folded checksum and
//   status (1 = protocol not supported, checksum then 0xFFFF).
// Throughput: one byte per cycle while o_out does not hold off the
//   pipeline, with no gaps between packets.
// Path: input register, two pseudo-header adder stages, accumulator,
//   fold and output register.
// Stall: the stages are elastic; while o_out is held off, bytes keep
//   being taken until the pipeline holds no free slot, then i_in.ready
//   drops. Bytes that are not the last pass the accumulator without
//   waiting on the output side.
// Reset: synchronous, active low; clears all valid flags and the running
//   sum and byte position, so the next byte starts a new packet.
module pseudo_header_internet_checksum (
    input  logic       i_clk,
    input  logic       i_rst_n,
    phic_in_if.sink    i_in,
    phic_out_if.source o_out
);

    logic              w_hdr_valid, w_hdr_ready;
    phic_pkg::t_acc_in w_acc;
    logic              w_fin_valid, w_fin_ready;
    phic_pkg::t_fin    w_fin;

    phic_hdr_sum u_hdr_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_hdr_valid),
        .i_ready (w_hdr_ready),
        .o_acc   (w_acc)
    );

    phic_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hdr_valid),
        .o_ready (w_hdr_ready),
        .i_acc   (w_acc),
        .o_valid (w_fin_valid),
        .i_ready (w_fin_ready),
        .o_fin   (w_fin)
    );

    phic_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fin_valid),
        .o_ready (w_fin_ready),
        .i_fin   (w_fin),
        .o_out   (o_out)
    );

endmodule

>>> sv/phic_checker.sv
`timescale 1ns / 1ps

module phic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last_byte,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_checksum,
    input logic        i_out_status
);

    localparam logic [2:0] MAX_PENDING = 3'd5;

    logic [2:0] r_pending;
    logic       w_last_acc, w_out_acc;

    assign w_last_acc = i_in_valid && i_in_ready && i_in_last_byte;
    assign w_out_acc  = i_out_valid && i_out_ready;

    // packets whose last byte is in but whose result is not yet out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_last_acc && !w_out_acc) begin
            r_pending <= r_pending + 3'd1;
        end else if (!w_last_acc && w_out_acc) begin
            r_pending <= r_pending - 3'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_checksum) && $stable(i_out_status))
        else $error("result changed while stalled");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_checksum == 16'hFFFF)
        else $error("error status without 0xFFFF checksum");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_pending != 3'd0)
        else $error("result without a packet end");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= MAX_PENDING)
        else $error("more packets in flight than pipeline slots");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind pseudo_header_internet_checksum phic_checker u_phic_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last_byte (i_in.last_byte),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_checksum (o_out.checksum),
    .i_out_status   (o_out.status)
);
